// File: src/pts_pkg.sv
package pts_pkg;

    localparam logic [2:0] FUNC_TICK       = 3'd0;
    localparam logic [2:0] FUNC_ADD        = 3'd1;
    localparam logic [2:0] FUNC_ENABLE     = 3'd2;
    localparam logic [2:0] FUNC_DISABLE    = 3'd3;
    localparam logic [2:0] FUNC_SET_PERIOD = 3'd4;
    localparam logic [2:0] FUNC_CLEAR      = 3'd5;

    // due tasks reported per tick at most
    localparam int MAX_RESULTS = 16;
    localparam int NF_W        = 5;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] tick_time;
        logic [7:0]  task_tag;
        logic [31:0] period;
        logic [7:0]  priority_req;
        logic [7:0]  position;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic        fired;
        logic [3:0]  fired_position;
        logic [7:0]  fired_tag;
        logic [4:0]  task_total;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] period;
        logic [31:0] last_run;
        logic [7:0]  prio;
        logic        enabled;
    } t_entry;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_DEC,
        PTR_INC
    } t_ptr_op;

    typedef enum logic [1:0] {
        RA_PTR,
        RA_PTR_M1,
        RA_POS
    } t_raddr;

    typedef enum logic {
        WA_PTR,
        WA_POS
    } t_waddr;

    typedef enum logic [1:0] {
        WD_NEW,
        WD_COPY,
        WD_RUN,
        WD_MOD
    } t_wdata;

    typedef enum logic {
        PUSH_PLAIN,
        PUSH_PEND
    } t_push_sel;

    typedef struct packed {
        logic      capture;
        logic      tick_start;
        t_ptr_op   ptr_op;
        logic      rd_en;
        t_raddr    raddr;
        logic      wr_en;
        t_waddr    waddr;
        t_wdata    wdata;
        logic      count_inc;
        logic      count_clr;
        logic      pend_load;
        logic      push;
        t_push_sel push_sel;
        logic      push_last;
        logic      ok;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       time_same;
        logic       add_bad;
        logic       pos_ok;
        logic       ptr_zero;
        logic       scan_done;
        logic       due;
        logic       prio_gt;
        logic       pend_valid;
        logic       out_free;
    } t_status;

endpackage

// File: src/periodic_task_scheduler.sv
// Channel   Valid         Ready         Payload
// input     i_in_valid    o_in_ready    i_in_data  (t_in)
// output    o_out_valid   i_out_ready   o_out_data (t_out)
//
// One item at a time; the entry table is a single-port-write memory with
// registered read, so each visited entry takes a read state and a check state.
// A tick with a new time scans tasks in order; an add shifts entries with a
// greater priority value up one place; enable/disable/set period rewrite the
// entry at its position; clear, rejected items, unused positions and ticks
// with an unchanged time go straight to the result.
// Reset clears the task count and the previous tick, no clearing pass.
// A stalled output holds the engine only when a new result must be written.
module periodic_task_scheduler import pts_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd    cmd;
    t_status status;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: src/pts_ctrl.sv
module pts_ctrl import pts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_INS_RD,
        S_INS_CHK,
        S_RMW_RD,
        S_RMW_WR,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_ok, n_ok;

    always_comb begin
        n_state    = r_state;
        n_ok       = r_ok;
        o_cmd      = '0;
        o_cmd.ok   = r_ok;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_status.func) inside
                    FUNC_TICK: begin
                        n_ok = 1'b1;
                        if (i_status.time_same) begin
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.tick_start = 1'b1;
                            o_cmd.ptr_op     = PTR_ZERO;
                            n_state          = S_SCAN_RD;
                        end
                    end
                    FUNC_ADD: begin
                        if (i_status.add_bad) begin
                            n_ok    = 1'b0;
                            n_state = S_EMIT;
                        end else begin
                            n_ok         = 1'b1;
                            o_cmd.ptr_op = PTR_COUNT;
                            n_state      = S_INS_RD;
                        end
                    end
                    FUNC_ENABLE, FUNC_DISABLE, FUNC_SET_PERIOD: begin
                        n_ok    = 1'b1;
                        n_state = i_status.pos_ok ? S_RMW_RD : S_EMIT;
                    end
                    FUNC_CLEAR: begin
                        n_ok            = 1'b1;
                        o_cmd.count_clr = 1'b1;
                        n_state         = S_EMIT;
                    end
                    default: begin
                        n_ok    = 1'b0;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (i_status.scan_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.raddr = RA_PTR;
                    n_state     = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_status.due) begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = S_SCAN_RD;
                end else if (!i_status.pend_valid || i_status.out_free) begin
                    // release the previous due task, it is not the final one
                    o_cmd.push      = i_status.pend_valid;
                    o_cmd.push_sel  = PUSH_PEND;
                    o_cmd.push_last = 1'b0;
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.waddr     = WA_PTR;
                    o_cmd.wdata     = WD_RUN;
                    o_cmd.pend_load = 1'b1;
                    o_cmd.ptr_op    = PTR_INC;
                    n_state         = S_SCAN_RD;
                end
            end
            S_INS_RD: begin
                if (i_status.ptr_zero) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.waddr     = WA_PTR;
                    o_cmd.wdata     = WD_NEW;
                    o_cmd.count_inc = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.raddr = RA_PTR_M1;
                    n_state     = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.waddr = WA_PTR;
                if (i_status.prio_gt) begin
                    // shift the neighbor up one place
                    o_cmd.wdata  = WD_COPY;
                    o_cmd.ptr_op = PTR_DEC;
                    n_state      = S_INS_RD;
                end else begin
                    o_cmd.wdata     = WD_NEW;
                    o_cmd.count_inc = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_RMW_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.raddr = RA_POS;
                n_state     = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.waddr = WA_POS;
                o_cmd.wdata = WD_MOD;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_sel  = i_status.pend_valid ? PUSH_PEND : PUSH_PLAIN;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
        end
    end

endmodule

// File: src/pts_dp.sv
module pts_dp import pts_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_in     i_in_data,
    input  logic    i_out_ready,
    output t_status o_status,
    output logic    o_out_valid,
    output t_out    o_out_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_entry          r_mem [TABLE_DEPTH];
    t_entry          r_rdata;
    t_in             r_item;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [NF_W-1:0] r_nfired;
    logic [31:0]     r_prev_tick;
    logic            r_pend_valid;
    logic [IW-1:0]   r_pend_pos;
    logic [7:0]      r_pend_tag;
    logic            r_out_valid;
    t_out            r_out;

    logic [CW-1:0]   ptr_m1;
    logic [IW-1:0]   raddr, waddr;
    t_entry          wdata;
    t_out            push_data;
    logic [31:0]     due_time;
    logic            out_free;

    assign ptr_m1   = r_ptr - CW'(1);
    assign due_time = r_rdata.last_run + r_rdata.period;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.raddr)
            RA_PTR:    raddr = r_ptr[IW-1:0];
            RA_PTR_M1: raddr = ptr_m1[IW-1:0];
            default:   raddr = r_item.position[IW-1:0];
        endcase
        waddr = (i_cmd.waddr == WA_POS) ? r_item.position[IW-1:0] : r_ptr[IW-1:0];
    end

    always_comb begin
        wdata = r_rdata;
        case (i_cmd.wdata)
            WD_NEW: begin
                wdata.tag      = r_item.task_tag;
                wdata.period   = r_item.period;
                wdata.last_run = '0;
                wdata.prio     = r_item.priority_req;
                wdata.enabled  = 1'b1;
            end
            WD_RUN: begin
                wdata.last_run = r_item.tick_time;
            end
            WD_MOD: begin
                case (r_item.func)
                    FUNC_ENABLE:  wdata.enabled = 1'b1;
                    FUNC_DISABLE: wdata.enabled = 1'b0;
                    default:      wdata.period  = r_item.period;
                endcase
            end
            default: begin
                wdata = r_rdata;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_ZERO:  n_ptr = '0;
            PTR_COUNT: n_ptr = r_count;
            PTR_DEC:   n_ptr = ptr_m1;
            PTR_INC:   n_ptr = r_ptr + CW'(1);
            default:   n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        push_data            = '0;
        push_data.task_total = 5'(r_count);
        push_data.last       = i_cmd.push_last;
        if (i_cmd.push_sel == PUSH_PEND) begin
            push_data.ok             = 1'b1;
            push_data.fired          = 1'b1;
            push_data.fired_position = 4'(r_pend_pos);
            push_data.fired_tag      = r_pend_tag;
        end else begin
            push_data.ok = i_cmd.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.pend_load) begin
            r_pend_pos <= r_ptr[IW-1:0];
            r_pend_tag <= r_rdata.tag;
        end
        if (i_cmd.push) begin
            r_out <= push_data;
        end
        r_ptr <= n_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_prev_tick  <= '0;
            r_nfired     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.tick_start) begin
                r_prev_tick <= r_item.tick_time;
                r_nfired    <= '0;
            end else if (i_cmd.pend_load) begin
                r_nfired <= r_nfired + NF_W'(1);
            end
            if (i_cmd.capture) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.pend_load) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.func       = r_item.func;
        o_status.time_same  = (r_item.tick_time == r_prev_tick);
        o_status.add_bad    = (r_item.task_tag == 8'd0) ||
                              (r_count == CW'(TABLE_DEPTH));
        o_status.pos_ok     = (r_item.position < 8'(r_count));
        o_status.ptr_zero   = (r_ptr == '0);
        o_status.scan_done  = (r_ptr == r_count) ||
                              (r_nfired == NF_W'(MAX_RESULTS));
        o_status.due        = r_rdata.enabled && (due_time <= r_item.tick_time);
        o_status.prio_gt    = (r_rdata.prio > r_item.priority_req);
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/pts_checker.sv
module pts_checker import pts_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a waiting input transaction holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while waiting");

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // the engine works on one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while engine busy");

    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fired |-> o_out_data.ok &&
        (o_out_data.fired_tag != 8'd0))
        else $error("fired result without ok or with tag zero");

    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.fired |-> o_out_data.last &&
        (o_out_data.fired_tag == 8'd0) && (o_out_data.fired_position == 4'd0))
        else $error("plain result not final or carries a task");

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
